### src/tlik_pkg.sv
// Shared types, codes and tables for the two-link arm inverse kinematics block.
`default_nettype none
package tlik_pkg;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_MUL,
    ST_MACC,
    ST_CHK,
    ST_SQ_INIT,
    ST_SQ_RUN,
    ST_CO_INIT,
    ST_CO_RUN,
    ST_DMUL,
    ST_DACC,
    ST_FIN
  } state_t;

  // result status codes
  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_CAL   = 2'd1;
  localparam logic [1:0] STAT_XNEG  = 2'd2;
  localparam logic [1:0] STAT_REACH = 2'd3;

  // register indexes
  localparam logic [2:0] REG_LINK   = 3'd0;
  localparam logic [2:0] REG_BASE_H = 3'd1;
  localparam logic [2:0] REG_HOME_X = 3'd2;
  localparam logic [2:0] REG_HOME_Y = 3'd3;
  localparam logic [2:0] REG_HOME_Z = 3'd4;

  localparam logic [15:0] LINK_RST   = 16'd3200;
  localparam logic [15:0] BASE_H_RST = 16'd2528;
  localparam logic [19:0] HOME_X_RST = 20'd2160;
  localparam logic [19:0] HOME_Y_RST = 20'd0;
  localparam logic [19:0] HOME_Z_RST = 20'd5568;

  // 23040/(pi*65536) in Q.32
  localparam logic signed [29:0] DEG_MULT = 30'sd480631834;

  localparam logic [4:0] SQ_LAST = 5'd25;  // 26 root bits

  // floor(atan(2^-i) * 2^30)
  function automatic logic [30:0] atan_q30(input logic [4:0] i);
    logic [30:0] v;
    case (i)
      5'd0:  v = 31'd843314856;
      5'd1:  v = 31'd497837829;
      5'd2:  v = 31'd263043836;
      5'd3:  v = 31'd133525158;
      5'd4:  v = 31'd67021686;
      5'd5:  v = 31'd33543515;
      5'd6:  v = 31'd16775850;
      5'd7:  v = 31'd8388437;
      5'd8:  v = 31'd4194282;
      5'd9:  v = 31'd2097149;
      5'd10: v = 31'd1048575;
      5'd11: v = 31'd524287;
      5'd12: v = 31'd262143;
      5'd13: v = 31'd131071;
      5'd14: v = 31'd65535;
      5'd15: v = 31'd32767;
      5'd16: v = 31'd16383;
      5'd17: v = 31'd8191;
      5'd18: v = 31'd4095;
      5'd19: v = 31'd2047;
      5'd20: v = 31'd1023;
      5'd21: v = 31'd511;
      5'd22: v = 31'd255;
      5'd23: v = 31'd127;
      5'd24: v = 31'd63;
      5'd25: v = 31'd31;
      5'd26: v = 31'd15;
      5'd27: v = 31'd7;
      5'd28: v = 31'd3;
      5'd29: v = 31'd1;
      default: v = 31'd0;
    endcase
    return v;
  endfunction

  // Q.30 to Q.16, round half up
  function automatic logic signed [18:0] q30_to_q16(input logic signed [32:0] a);
    logic signed [32:0] t;
    t = a + 33'sd8192;
    return t[32:14];
  endfunction

endpackage
`default_nettype wire

### src/two_link_arm_inverse_kinematics.sv
// Top level: two-link arm inverse kinematics on a shared multiplier, root and CORDIC unit.
// Each input beat runs in turn through the steps below before its result is offered:
//   4 squares, 3 roots at one bit a cycle, 3 CORDIC passes, 3 degree scalings.
//   A rejected point skips the roots, CORDIC and scalings; the calibration pass skips the scalings.
// One item at a time: in_ready is high only while idle, so a new target waits for the last result.
// Reset (rst_n low, synchronous): registers to defaults, uncalibrated, no result pending.
`default_nettype none
module two_link_arm_inverse_kinematics #(
  parameter int CORDIC_STEPS = 20
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_ready,
  input  wire logic signed [19:0] in_target_x,
  input  wire logic signed [19:0] in_target_y,
  input  wire logic signed [19:0] in_target_z,
  output logic                    out_valid,
  input  wire logic               out_ready,
  output logic [1:0]              out_status,
  output logic signed [18:0]      out_base_rad,
  output logic signed [18:0]      out_shoulder_rad,
  output logic signed [18:0]      out_wrist_rad,
  output logic signed [16:0]      out_base_deg,
  output logic signed [16:0]      out_shoulder_deg,
  output logic signed [16:0]      out_wrist_deg,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [4:0]         paddr,
  input  wire logic [31:0]        pwdata,
  output logic [31:0]             prdata,
  output logic                    pready
);
  import tlik_pkg::*;

  localparam logic [4:0] CO_LAST = 5'(CORDIC_STEPS - 1);

  state_t state_r, state_nxt;
  logic [1:0] sel_r, sel_nxt;
  logic [4:0] cnt_r, cnt_nxt;
  logic calib_r, calib_nxt;
  logic [1:0] status_r, status_nxt;

  logic [15:0] link_r, base_h_r;
  logic [19:0] home_x_r, home_y_r, home_z_r;

  logic signed [19:0] x_r, x_nxt, y_r, y_nxt;
  logic signed [20:0] z_r, z_nxt;
  logic signed [50:0] prod_r, prod_nxt;
  logic [40:0] xy2_r, xy2_nxt, s2_r, s2_nxt;
  logic [33:0] reach_r, reach_nxt;
  logic [51:0] rad_r, rad_nxt;
  logic [29:0] rem_r, rem_nxt;
  logic [25:0] root_r, root_nxt;
  logic [25:0] lq_r, lq_nxt, hq_r, hq_nxt, rq_r, rq_nxt;
  logic signed [29:0] cx_r, cx_nxt, cy_r, cy_nxt;
  logic signed [32:0] acc_r, acc_nxt, phi_r, phi_nxt;
  logic signed [18:0] bq_r, bq_nxt, sq_r, sq_nxt, wq_r, wq_nxt;
  logic signed [18:0] offb_r, offb_nxt, offs_r, offs_nxt, offw_r, offw_nxt;
  logic signed [16:0] bd_r, bd_nxt, sd_r, sd_nxt, wd_r, wd_nxt;

  logic out_valid_r, out_valid_nxt;
  logic [1:0] o_status_r, o_status_nxt;
  logic signed [18:0] o_b_r, o_b_nxt, o_s_r, o_s_nxt, o_w_r, o_w_nxt;
  logic signed [16:0] o_bd_r, o_bd_nxt, o_sd_r, o_sd_nxt, o_wd_r, o_wd_nxt;

  // shared multiplier
  logic signed [20:0] mul_a;
  logic signed [29:0] mul_b;
  logic signed [50:0] mul_p;
  assign mul_p = 51'(mul_a) * 51'(mul_b);

  // root step
  logic [29:0] rem_sh, trial;
  logic [25:0] root_step;
  logic [33:0] sq_src;

  // CORDIC step
  logic signed [29:0] cx_step, cy_step;
  logic signed [32:0] acc_step, tab_ext;

  logic signed [19:0] diff;
  logic signed [51:0] deg_rnd;

  logic cfg_wr;
  assign cfg_wr = psel & penable & pwrite;
  assign pready = 1'b1;

  always_comb begin
    case (paddr[4:2])
      REG_LINK:   prdata = {16'd0, link_r};
      REG_BASE_H: prdata = {16'd0, base_h_r};
      REG_HOME_X: prdata = {12'd0, home_x_r};
      REG_HOME_Y: prdata = {12'd0, home_y_r};
      REG_HOME_Z: prdata = {12'd0, home_z_r};
      default:    prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      link_r   <= LINK_RST;
      base_h_r <= BASE_H_RST;
      home_x_r <= HOME_X_RST;
      home_y_r <= HOME_Y_RST;
      home_z_r <= HOME_Z_RST;
    end else if (cfg_wr) begin
      case (paddr[4:2])
        REG_LINK:   link_r   <= pwdata[15:0];
        REG_BASE_H: base_h_r <= pwdata[15:0];
        REG_HOME_X: home_x_r <= pwdata[19:0];
        REG_HOME_Y: home_y_r <= pwdata[19:0];
        REG_HOME_Z: home_z_r <= pwdata[19:0];
        default: ;
      endcase
    end
  end

  assign in_ready = (state_r == ST_IDLE);
  assign out_valid = out_valid_r;
  assign out_status = o_status_r;
  assign out_base_rad = o_b_r;
  assign out_shoulder_rad = o_s_r;
  assign out_wrist_rad = o_w_r;
  assign out_base_deg = o_bd_r;
  assign out_shoulder_deg = o_sd_r;
  assign out_wrist_deg = o_wd_r;

  always_comb begin
    // datapath helpers
    rem_sh = {rem_r[27:0], rad_r[51:50]};
    trial = {2'b00, root_r, 2'b01};
    root_step = (rem_sh >= trial) ? {root_r[24:0], 1'b1} : {root_r[24:0], 1'b0};

    case (sel_r)
      2'd0:    sq_src = xy2_r[33:0];
      2'd1:    sq_src = s2_r[33:0];
      default: sq_src = reach_r - s2_r[33:0];
    endcase

    tab_ext = 33'(atan_q30(cnt_r));
    if (!cy_r[29]) begin
      cx_step  = cx_r + (cy_r >>> cnt_r);
      cy_step  = cy_r - (cx_r >>> cnt_r);
      acc_step = acc_r + tab_ext;
    end else begin
      cx_step  = cx_r - (cy_r >>> cnt_r);
      cy_step  = cy_r + (cx_r >>> cnt_r);
      acc_step = acc_r - tab_ext;
    end

    case (sel_r)
      2'd0:    diff = 20'(bq_r) - 20'(offb_r);
      2'd1:    diff = 20'(sq_r) - 20'(offs_r);
      default: diff = 20'(wq_r) - 20'(offw_r);
    endcase
    deg_rnd = 52'(prod_r) + 52'sd2147483648;

    mul_a = 21'sd0;
    mul_b = 30'sd0;
    if (state_r == ST_DMUL) begin
      mul_a = 21'(diff);
      mul_b = DEG_MULT;
    end else begin
      case (sel_r)
        2'd0:    mul_a = 21'(x_r);
        2'd1:    mul_a = 21'(y_r);
        2'd2:    mul_a = z_r;
        default: mul_a = $signed({5'd0, link_r});
      endcase
      mul_b = 30'(mul_a);
    end

    // defaults
    state_nxt = state_r; sel_nxt = sel_r; cnt_nxt = cnt_r; calib_nxt = calib_r;
    status_nxt = status_r;
    x_nxt = x_r; y_nxt = y_r; z_nxt = z_r; prod_nxt = prod_r;
    xy2_nxt = xy2_r; s2_nxt = s2_r; reach_nxt = reach_r;
    rad_nxt = rad_r; rem_nxt = rem_r; root_nxt = root_r;
    lq_nxt = lq_r; hq_nxt = hq_r; rq_nxt = rq_r;
    cx_nxt = cx_r; cy_nxt = cy_r; acc_nxt = acc_r; phi_nxt = phi_r;
    bq_nxt = bq_r; sq_nxt = sq_r; wq_nxt = wq_r;
    offb_nxt = offb_r; offs_nxt = offs_r; offw_nxt = offw_r;
    bd_nxt = bd_r; sd_nxt = sd_r; wd_nxt = wd_r;
    out_valid_nxt = out_valid_r & ~out_ready;
    o_status_nxt = o_status_r; o_b_nxt = o_b_r; o_s_nxt = o_s_r; o_w_nxt = o_w_r;
    o_bd_nxt = o_bd_r; o_sd_nxt = o_sd_r; o_wd_nxt = o_wd_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          if (calib_r) begin
            x_nxt = in_target_x;
            y_nxt = in_target_y;
            z_nxt = 21'(in_target_z) - $signed({5'd0, base_h_r});
          end else begin
            x_nxt = home_x_r;
            y_nxt = home_y_r;
            z_nxt = 21'($signed(home_z_r)) - $signed({5'd0, base_h_r});
          end
          status_nxt = STAT_OK;
          sel_nxt = 2'd0;
          state_nxt = ST_MUL;
        end
      end
      ST_MUL: begin
        prod_nxt = mul_p;
        state_nxt = ST_MACC;
      end
      ST_MACC: begin
        case (sel_r)
          2'd0:    xy2_nxt = prod_r[40:0];
          2'd1:    xy2_nxt = xy2_r + prod_r[40:0];
          2'd2:    s2_nxt = xy2_r + prod_r[40:0];
          default: reach_nxt = {prod_r[31:0], 2'b00};
        endcase
        sel_nxt = sel_r + 2'd1;
        state_nxt = (sel_r == 2'd3) ? ST_CHK : ST_MUL;
      end
      ST_CHK: begin
        sel_nxt = 2'd0;
        if (x_r[19] || x_r == 20'sd0) begin
          status_nxt = STAT_XNEG;
          state_nxt = ST_FIN;
        end else if (s2_r > {7'd0, reach_r}) begin
          status_nxt = STAT_REACH;
          state_nxt = ST_FIN;
        end else begin
          state_nxt = ST_SQ_INIT;
        end
      end
      ST_SQ_INIT: begin
        rad_nxt = {2'b00, sq_src, 16'd0};
        rem_nxt = 30'd0;
        root_nxt = 26'd0;
        cnt_nxt = 5'd0;
        state_nxt = ST_SQ_RUN;
      end
      ST_SQ_RUN: begin
        rem_nxt = (rem_sh >= trial) ? rem_sh - trial : rem_sh;
        root_nxt = root_step;
        rad_nxt = {rad_r[49:0], 2'b00};
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == SQ_LAST) begin
          case (sel_r)
            2'd0:    lq_nxt = root_step;
            2'd1:    hq_nxt = root_step;
            default: rq_nxt = root_step;
          endcase
          if (sel_r == 2'd2) begin
            sel_nxt = 2'd0;
            state_nxt = ST_CO_INIT;
          end else begin
            sel_nxt = sel_r + 2'd1;
            state_nxt = ST_SQ_INIT;
          end
        end
      end
      ST_CO_INIT: begin
        case (sel_r)
          2'd0: begin
            cx_nxt = 30'(x_r);
            cy_nxt = 30'(y_r);
          end
          2'd1: begin
            cx_nxt = $signed({4'd0, lq_r});
            cy_nxt = $signed({z_r[20], z_r, 8'd0});
          end
          default: begin
            cx_nxt = $signed({4'd0, hq_r});
            cy_nxt = $signed({4'd0, rq_r});
          end
        endcase
        acc_nxt = 33'sd0;
        cnt_nxt = 5'd0;
        state_nxt = ST_CO_RUN;
      end
      ST_CO_RUN: begin
        cx_nxt = cx_step;
        cy_nxt = cy_step;
        acc_nxt = acc_step;
        cnt_nxt = cnt_r + 5'd1;
        if (cnt_r == CO_LAST) begin
          case (sel_r)
            2'd0: begin
              bq_nxt = q30_to_q16(acc_step);
              sel_nxt = 2'd1;
              state_nxt = ST_CO_INIT;
            end
            2'd1: begin
              phi_nxt = acc_step;
              sel_nxt = 2'd2;
              state_nxt = ST_CO_INIT;
            end
            default: begin
              sq_nxt = q30_to_q16(phi_r + acc_step);
              wq_nxt = q30_to_q16(phi_r - acc_step);
              sel_nxt = 2'd0;
              if (!calib_r) begin
                offb_nxt = bq_r;
                offs_nxt = q30_to_q16(phi_r + acc_step);
                offw_nxt = q30_to_q16(phi_r - acc_step);
                calib_nxt = 1'b1;
                status_nxt = STAT_CAL;
                state_nxt = ST_FIN;
              end else begin
                state_nxt = ST_DMUL;
              end
            end
          endcase
        end
      end
      ST_DMUL: begin
        prod_nxt = mul_p;
        state_nxt = ST_DACC;
      end
      ST_DACC: begin
        case (sel_r)
          2'd0:    bd_nxt = deg_rnd[48:32];
          2'd1:    sd_nxt = deg_rnd[48:32];
          default: wd_nxt = deg_rnd[48:32];
        endcase
        sel_nxt = sel_r + 2'd1;
        state_nxt = (sel_r == 2'd2) ? ST_FIN : ST_DMUL;
      end
      ST_FIN: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          o_status_nxt = status_r;
          if (status_r == STAT_OK) begin
            o_b_nxt = bq_r;  o_s_nxt = sq_r;  o_w_nxt = wq_r;
            o_bd_nxt = bd_r; o_sd_nxt = sd_r; o_wd_nxt = wd_r;
          end else begin
            o_b_nxt = '0;  o_s_nxt = '0;  o_w_nxt = '0;
            o_bd_nxt = '0; o_sd_nxt = '0; o_wd_nxt = '0;
          end
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      sel_r <= 2'd0;
      cnt_r <= 5'd0;
      calib_r <= 1'b0;
      status_r <= STAT_OK;
      offb_r <= '0;
      offs_r <= '0;
      offw_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      sel_r <= sel_nxt;
      cnt_r <= cnt_nxt;
      calib_r <= calib_nxt;
      status_r <= status_nxt;
      offb_r <= offb_nxt;
      offs_r <= offs_nxt;
      offw_r <= offw_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    x_r <= x_nxt; y_r <= y_nxt; z_r <= z_nxt; prod_r <= prod_nxt;
    xy2_r <= xy2_nxt; s2_r <= s2_nxt; reach_r <= reach_nxt;
    rad_r <= rad_nxt; rem_r <= rem_nxt; root_r <= root_nxt;
    lq_r <= lq_nxt; hq_r <= hq_nxt; rq_r <= rq_nxt;
    cx_r <= cx_nxt; cy_r <= cy_nxt; acc_r <= acc_nxt; phi_r <= phi_nxt;
    bq_r <= bq_nxt; sq_r <= sq_nxt; wq_r <= wq_nxt;
    bd_r <= bd_nxt; sd_r <= sd_nxt; wd_r <= wd_nxt;
    o_status_r <= o_status_nxt;
    o_b_r <= o_b_nxt; o_s_r <= o_s_nxt; o_w_r <= o_w_nxt;
    o_bd_r <= o_bd_nxt; o_sd_r <= o_sd_nxt; o_wd_r <= o_wd_nxt;
  end

  // once calibrated, stays calibrated until reset
  a_calib_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    calib_r |=> calib_r) else $error("calibration flag dropped");

  // valid angles only come after calibration
  a_ok_needs_calib: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r == STAT_OK) |-> calib_r)
    else $error("angles given while uncalibrated");

  // failed or calibration beats carry zero angles
  a_fail_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && o_status_r != STAT_OK) |->
      (o_b_r == '0 && o_s_r == '0 && o_w_r == '0 && o_bd_r == '0 &&
       o_sd_r == '0 && o_wd_r == '0))
    else $error("nonzero angle on non-ok beat");

  // root iteration count stays in range
  a_sq_cnt: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SQ_RUN) |-> (cnt_r <= SQ_LAST))
    else $error("root counter overran");

endmodule
`default_nettype wire

### dv/tlik_result_checker.sv
// Result checker: follows register writes and input beats, predicts each result, compares.
module tlik_result_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_ready,
  input  logic signed [19:0] in_target_x,
  input  logic signed [19:0] in_target_y,
  input  logic signed [19:0] in_target_z,
  input  logic               out_valid,
  input  logic               out_ready,
  input  logic [1:0]         out_status,
  input  logic signed [18:0] out_base_rad,
  input  logic signed [18:0] out_shoulder_rad,
  input  logic signed [18:0] out_wrist_rad,
  input  logic signed [16:0] out_base_deg,
  input  logic signed [16:0] out_shoulder_deg,
  input  logic signed [16:0] out_wrist_deg,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  input  logic               pready,
  output int                 n_pending,
  output int                 n_fail
);
  import tlik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ROT_STEPS = 20;
  localparam longint DEG_SCALE = 64'sd480631834;
  localparam longint QUARTER_TURN = 64'sd1686629713;
  localparam longint ATAN_Q30 [32] = '{
    843314856, 497837829, 263043836, 133525158, 67021686, 33543515,
    16775850, 8388437, 4194282, 2097149, 1048575, 524287, 262143, 131071,
    65535, 32767, 16383, 8191, 4095, 2047, 1023, 511, 255, 127, 63, 31,
    15, 7, 3, 1, 0, 0};

  typedef struct {
    logic [1:0]         status;
    logic signed [18:0] base_rad;
    logic signed [18:0] shoulder_rad;
    logic signed [18:0] wrist_rad;
    logic signed [16:0] base_deg;
    logic signed [16:0] shoulder_deg;
    logic signed [16:0] wrist_deg;
  } pose_t;

  // register copy and calibration state
  logic [15:0]        link_len;
  logic [15:0]        base_h;
  logic signed [19:0] home_x, home_y, home_z;
  logic               is_cal;
  longint             off_b, off_s, off_w;
  pose_t              pose_q[$];
  int                 n_err = 0;

  function automatic longint unsigned root_floor(longint unsigned v);
    longint unsigned r, bv;
    r = 0;
    bv = 64'd1 << 62;
    while (bv > v) bv = bv >> 2;
    while (bv != 0) begin
      if (v >= r + bv) begin
        v = v - (r + bv);
        r = (r >> 1) + bv;
      end else begin
        r = r >> 1;
      end
      bv = bv >> 2;
    end
    return r;
  endfunction

  function automatic longint vector_angle(longint y, longint x);
    longint a, t, nx;
    a = 0;
    if (x < 0) begin
      t = x;
      if (y >= 0) begin
        x = y; y = -t; a = QUARTER_TURN;
      end else begin
        x = -y; y = t; a = -QUARTER_TURN;
      end
    end
    for (int i = 0; i < ROT_STEPS && i < 32; i++) begin
      if (y >= 0) begin
        nx = x + (y >>> i);
        y  = y - (x >>> i);
        a  = a + ATAN_Q30[i];
      end else begin
        nx = x - (y >>> i);
        y  = y + (x >>> i);
        a  = a - ATAN_Q30[i];
      end
      x = nx;
    end
    return a;
  endfunction

  function automatic longint round_q16(longint a);
    return (a + 8192) >>> 14;
  endfunction

  function automatic longint rad_to_deg(longint d);
    return (d * DEG_SCALE + (64'sd1 <<< 31)) >>> 32;
  endfunction

  function automatic logic [1:0] solve_arm(longint x, longint y, longint z,
                                           output longint b, output longint s,
                                           output longint w);
    longint unsigned xy2, s2, reach2, lq, hq, rq;
    longint phi, theta;
    b = 0; s = 0; w = 0;
    if (x <= 0) return STAT_XNEG;
    xy2 = x * x + y * y;
    s2 = xy2 + z * z;
    reach2 = 4 * longint'(link_len) * longint'(link_len);
    if (s2 > reach2) return STAT_REACH;
    lq = root_floor(xy2 << 16);
    hq = root_floor(s2 << 16);
    rq = root_floor((reach2 - s2) << 16);
    phi = vector_angle(z * 256, longint'(lq));
    theta = vector_angle(longint'(rq), longint'(hq));
    b = round_q16(vector_angle(y, x));
    s = round_q16(phi + theta);
    w = round_q16(phi - theta);
    return STAT_OK;
  endfunction

  function automatic pose_t predict_pose(longint tx, longint ty, longint tz);
    pose_t  p;
    longint x, y, z, b, s, w, bd, sd, wd;
    logic [1:0] st;
    bd = 0; sd = 0; wd = 0;
    if (!is_cal) begin
      x = home_x; y = home_y; z = home_z;
    end else begin
      x = tx; y = ty; z = tz;
    end
    z = z - longint'(base_h);
    st = solve_arm(x, y, z, b, s, w);
    if (st != STAT_OK) begin
      b = 0; s = 0; w = 0;
    end else if (!is_cal) begin
      off_b = b; off_s = s; off_w = w;
      is_cal = 1'b1;
      st = STAT_CAL;
      b = 0; s = 0; w = 0;
    end else begin
      bd = rad_to_deg(b - off_b);
      sd = rad_to_deg(s - off_s);
      wd = rad_to_deg(w - off_w);
    end
    p.status = st;
    p.base_rad = b[18:0];
    p.shoulder_rad = s[18:0];
    p.wrist_rad = w[18:0];
    p.base_deg = bd[16:0];
    p.shoulder_deg = sd[16:0];
    p.wrist_deg = wd[16:0];
    return p;
  endfunction

  always @(posedge clk) begin
    pose_t e;
    if (!rst_n) begin
      link_len = LINK_RST;
      base_h = BASE_H_RST;
      home_x = HOME_X_RST;
      home_y = HOME_Y_RST;
      home_z = HOME_Z_RST;
      is_cal = 1'b0;
      off_b = 0; off_s = 0; off_w = 0;
      pose_q.delete();
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_LINK:   link_len = pwdata[15:0];
          REG_BASE_H: base_h = pwdata[15:0];
          REG_HOME_X: home_x = pwdata[19:0];
          REG_HOME_Y: home_y = pwdata[19:0];
          REG_HOME_Z: home_z = pwdata[19:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready)
        pose_q.push_back(predict_pose(in_target_x, in_target_y, in_target_z));
      if (out_valid && out_ready) begin
        if (pose_q.size() == 0) begin
          n_err++;
          if (n_err <= 10) $display("unexpected result beat, status %0d", out_status);
        end else begin
          e = pose_q.pop_front();
          if (e.status !== out_status || e.base_rad !== out_base_rad ||
              e.shoulder_rad !== out_shoulder_rad || e.wrist_rad !== out_wrist_rad ||
              e.base_deg !== out_base_deg || e.shoulder_deg !== out_shoulder_deg ||
              e.wrist_deg !== out_wrist_deg) begin
            n_err++;
            if (n_err <= 10) begin
              $display("mismatch: exp st %0d rad %0d %0d %0d deg %0d %0d %0d",
                       e.status, e.base_rad, e.shoulder_rad, e.wrist_rad,
                       e.base_deg, e.shoulder_deg, e.wrist_deg);
              $display("          got st %0d rad %0d %0d %0d deg %0d %0d %0d",
                       out_status, out_base_rad, out_shoulder_rad, out_wrist_rad,
                       out_base_deg, out_shoulder_deg, out_wrist_deg);
            end
          end
        end
      end
    end
    n_pending = pose_q.size();
    n_fail = n_err + n_pending;
  end

endmodule

### dv/two_link_arm_inverse_kinematics_test.sv
// Testbench top: clock, reset, register writes, target and result-side traffic, verdict.
module two_link_arm_inverse_kinematics_test;
  import tlik_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LIMIT_CYCLES = 1500000;
  localparam int DRAIN_CYCLES = 200;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic signed [19:0] in_target_x, in_target_y, in_target_z;
  logic               out_valid;
  logic               out_ready;
  logic [1:0]         out_status;
  logic signed [18:0] out_base_rad, out_shoulder_rad, out_wrist_rad;
  logic signed [16:0] out_base_deg, out_shoulder_deg, out_wrist_deg;
  logic               psel, penable, pwrite;
  logic [4:0]         paddr;
  logic [31:0]        pwdata;
  logic [31:0]        prdata;
  logic               pready;
  int                 n_pending, n_fail;
  int                 n_sent;
  int                 n_cycles = 0;
  int                 hold_req, hold_done;
  int                 n_settings;
  int                 cur_link, cur_base;

  two_link_arm_inverse_kinematics i_dut (.*);

  tlik_result_checker i_checker (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) n_sent <= 0;
    else if (in_valid && in_ready) n_sent <= n_sent + 1;
    n_cycles <= n_cycles + 1;
    if (n_cycles > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles, %0d results outstanding", n_cycles, n_pending);
      $display("tb: failure");
      $finish;
    end
  end

  // result side: random stalls, ready stretches, and long hold-offs on request
  initial begin
    int r;
    out_ready = 1'b0;
    hold_done = 0;
    forever begin
      @(negedge clk);
      if (hold_req != hold_done) begin
        out_ready <= 1'b0;
        repeat (800) @(negedge clk);
        hold_done++;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 4) begin
          out_ready <= 1'b0;
          repeat ($urandom_range(10, 60)) @(negedge clk);
        end else if (r < 8) begin
          out_ready <= 1'b1;
          repeat (150) @(negedge clk);
        end else begin
          out_ready <= (r < 70);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 95) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (idx == REG_LINK) cur_link = int'(val[15:0]);
    if (idx == REG_BASE_H) cur_base = int'(val[15:0]);
  endtask

  // settle: stop offering, wait for every result, then let the block go quiet
  task automatic drain();
    in_valid <= 1'b0;
    while (n_pending != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic send_target(input int x, input int y, input int z, input int gap);
    int goal;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_target_x <= x[19:0];
    in_target_y <= y[19:0];
    in_target_z <= z[19:0];
    goal = n_sent + 1;
    while (n_sent < goal) @(negedge clk);
  endtask

  task automatic send_random();
    int r, x, y, z, span;
    r = $urandom_range(0, 99);
    span = (cur_link < 1) ? 1 : cur_link;
    if (r < 65) begin
      x = $urandom_range(1, span);
      y = int'($urandom_range(0, 2 * span)) - span;
      z = int'($urandom_range(0, 2 * span)) - span + cur_base;
    end else if (r < 80) begin
      x = $urandom;
      y = $urandom;
      z = $urandom;
    end else if (r < 90) begin
      x = -int'($urandom_range(0, 524288));
      y = $urandom;
      z = $urandom;
    end else begin
      // reach boundary: exactly 2L reaches, one more does not
      x = 2 * cur_link + int'($urandom_range(0, 1));
      y = 0;
      z = cur_base;
    end
    send_target(x, y, z, pick_gap());
  endtask

  task automatic run_setting(input int link, input int base_hgt, input int hx, input int hy,
                             input int hz, input int count, input bit with_hold);
    drain();
    reg_write(REG_LINK, link);
    reg_write(REG_BASE_H, base_hgt);
    reg_write(REG_HOME_X, hx & 20'hFFFFF);
    reg_write(REG_HOME_Y, hy & 20'hFFFFF);
    reg_write(REG_HOME_Z, hz & 20'hFFFFF);
    n_settings++;
    for (int i = 0; i < count; i++) begin
      if (with_hold && i == count / 2) hold_req++;
      send_random();
    end
  endtask

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_target_x = '0;
    in_target_y = '0;
    in_target_z = '0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    hold_req = 0;
    n_settings = 0;
    cur_link = int'(LINK_RST);
    cur_base = int'(BASE_H_RST);
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // home pose with x not positive: stays uncalibrated
    reg_write(REG_HOME_X, 32'hFF790);
    reg_write(REG_HOME_Y, 32'd0);
    reg_write(REG_HOME_Z, 32'd5568);
    send_target(100, 100, 100, 0);
    send_target(-1, 7, 9, 1);
    drain();
    // home out of reach, including a zero link
    reg_write(REG_HOME_X, 32'd2160);
    reg_write(REG_LINK, 32'd0);
    send_target(5, 5, 5, 0);
    drain();
    reg_write(REG_LINK, 32'd1);
    send_target(5, 5, 5, 0);
    drain();
    reg_write(REG_LINK, 32'd3200);
    send_target(2160, 0, 5568, 0);   // calibrates
    send_target(524287, -524288, -524288, 0);
    send_target(1, 0, 2528, 0);
    send_target(0, 5, 5, 2);
    send_target(-524288, 0, 0, 0);
    send_target(6400, 0, 2528, 0);
    send_target(6401, 0, 2528, 0);
    send_target(100, -100, -472, 3);
    send_target(3000, 3000, 3528, 0);
    send_target(1, 524287, 2528, 0);
    send_target(2000, -3000, 5000, 0);
    send_target(1, -1, 2528, 0);
    send_target(2160, 0, 5568, 0);
    send_target(4, -524288, 524287, 0);

    // sender pause until all results are back, then random work
    run_setting(3200, 2528, 2160, 0, 5568, 240, 1'b1);
    run_setting(65535, 0, 524287, -524288, -524288, 240, 1'b0);
    run_setting(1, 65535, -524288, 524287, 524287, 240, 1'b1);
    run_setting(40000, 30000, 1, -1, 0, 240, 1'b0);
    run_setting(3200, 2528, 2160, 0, 5568, 240, 1'b0);

    drain();
    $display("%0d targets over %0d register settings, with calibration failures, zero link,",
             n_sent, n_settings);
    $display("reach boundary, non-positive x and long result-side stalls");
    if (n_fail == 0) begin
      $display("tb: success");
    end else begin
      $display("%0d failures", n_fail);
      $display("tb: failure");
    end
    $finish;
  end

endmodule
